// ===== rtl/rau_pkg.sv =====
package rau_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam logic [2:0] KIND_ADD  = 3'd0;
  localparam logic [2:0] KIND_SUB  = 3'd1;
  localparam logic [2:0] KIND_MUL  = 3'd2;
  localparam logic [2:0] KIND_DIV  = 3'd3;
  localparam logic [2:0] KIND_SIGN = 3'd4;
  localparam logic [2:0] KIND_EQ   = 3'd5;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_RANGE = 2'd1;
  localparam logic [1:0] ERR_ZDEN  = 2'd2;

  localparam logic [1:0] VERD_ZERO = 2'b00;
  localparam logic [1:0] VERD_POS  = 2'b01;
  localparam logic [1:0] VERD_NEG  = 2'b11;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SIGN, OP_EQ, OP_NONE
  } op_t;

  typedef struct packed {
    op_t  op;
    logic zden;
  } cls_t;

  typedef enum logic [2:0] {
    B_IDLE, B_MUL, B_SET, B_GCD, B_DIV, B_FIN
  } bstate_t;

endpackage

// ===== rtl/rational_arithmetic_unit.sv =====
// Channel  | Handshake          | Word
// ---------+--------------------+------------------------------------------
// input    | start, busy        | kind, a_num, a_den, b_num, b_den
// result   | done (one cycle)   | res_num, res_den, verdict, error
//
// A word is taken when start is high and busy is low; a two-word queue sits
// between intake and the execution unit, so busy rises only when it is full.
// Sign, unused kinds and zero-denominator words finish as they leave the queue;
// equality and words with a zero result finish after the multiplies.
// Others: 3 multiplies on the shared multiplier, a binary gcd and a
// shift-subtract division that yields 2*FRAC_BITS quotient bits.
// Synchronous reset empties the queue; results cannot be stalled.
module rational_arithmetic_unit #(
  parameter int FRAC_BITS = rau_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           kind,
  input  logic [FRAC_BITS-1:0] a_num,
  input  logic [FRAC_BITS-1:0] a_den,
  input  logic [FRAC_BITS-1:0] b_num,
  input  logic [FRAC_BITS-1:0] b_den,
  output logic                 done,
  output logic [FRAC_BITS-1:0] res_num,
  output logic [FRAC_BITS-1:0] res_den,
  output logic [1:0]           verdict,
  output logic [1:0]           error
);
  import rau_pkg::*;

  localparam int QW = 4 * FRAC_BITS + $bits(cls_t);

  logic                   push, pop, empty, full;
  cls_t                   wcls, rcls;
  logic [4*FRAC_BITS-1:0] witem, ritem;

  assign busy = full;

  rau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .start(start), .full(full), .kind(kind),
    .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
    .push(push), .cls(wcls), .item(witem)
  );

  rau_queue #(.DW(QW)) u_queue (
    .clk(clk), .rst(rst), .push(push), .wdata({wcls, witem}),
    .pop(pop), .rdata({rcls, ritem}), .empty(empty), .full(full)
  );

  rau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .empty(empty), .cls(rcls), .item(ritem),
    .pop(pop), .done(done), .res_num(res_num), .res_den(res_den),
    .verdict(verdict), .error(error)
  );

endmodule

// ===== rtl/rau_front.sv =====
module rau_front #(
  parameter int FRAC_BITS = rau_pkg::FRAC_BITS_DEF
) (
  input  logic                   start,
  input  logic                   full,
  input  logic [2:0]             kind,
  input  logic [FRAC_BITS-1:0]   a_num,
  input  logic [FRAC_BITS-1:0]   a_den,
  input  logic [FRAC_BITS-1:0]   b_num,
  input  logic [FRAC_BITS-1:0]   b_den,
  output logic                   push,
  output rau_pkg::cls_t          cls,
  output logic [4*FRAC_BITS-1:0] item
);
  import rau_pkg::*;

  logic ad_zero, bd_zero, bn_zero;

  assign ad_zero = (a_den == '0);
  assign bd_zero = (b_den == '0);
  assign bn_zero = (b_num == '0);
  assign push    = start && !full;
  assign item    = {a_num, a_den, b_num, b_den};

  always_comb begin
    unique case (kind)
      KIND_ADD:  cls.op = OP_ADD;
      KIND_SUB:  cls.op = OP_SUB;
      KIND_MUL:  cls.op = OP_MUL;
      KIND_DIV:  cls.op = OP_DIV;
      KIND_SIGN: cls.op = OP_SIGN;
      KIND_EQ:   cls.op = OP_EQ;
      default:   cls.op = OP_NONE;
    endcase
    unique case (cls.op)
      OP_SIGN: cls.zden = ad_zero;
      OP_NONE: cls.zden = 1'b0;
      OP_DIV:  cls.zden = ad_zero || bd_zero || bn_zero;
      default: cls.zden = ad_zero || bd_zero;
    endcase
  end

endmodule

// ===== rtl/rau_queue.sv =====
module rau_queue #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  input  logic          pop,
  output logic [DW-1:0] rdata,
  output logic          empty,
  output logic          full
);
  logic [DW-1:0] mem [2];
  logic          wptr, rptr;
  logic [1:0]    count;

  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

endmodule

// ===== rtl/rau_back.sv =====
module rau_back #(
  parameter int FRAC_BITS = rau_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   empty,
  input  rau_pkg::cls_t          cls,
  input  logic [4*FRAC_BITS-1:0] item,
  output logic                   pop,
  output logic                   done,
  output logic [FRAC_BITS-1:0]   res_num,
  output logic [FRAC_BITS-1:0]   res_den,
  output logic [1:0]             verdict,
  output logic [1:0]             error
);
  import rau_pkg::*;

  localparam int W  = FRAC_BITS;
  localparam int D  = 2 * FRAC_BITS;
  localparam int CW = $clog2(D + 1);
  localparam logic [D-1:0] HALF = D'(1) << (W - 1);

  bstate_t st, st_next;
  op_t     op;
  logic [1:0]    step;
  logic [W-1:0]  an, ad, bn, bd, qan, qad, qbn, qbd;
  logic [W-1:0]  man, mad, mbn, mbd, opa, opb;
  logic [D-1:0]  prod, p0, p1, p2;
  logic [D-1:0]  x, y, g, qn, qd, rn, rd;
  logic [CW-1:0] k, cnt;
  logic          nn, nd;
  logic [D:0]    tn, td;
  logic          n1, n2, sa, sb;

  assign {qan, qad, qbn, qbd} = item;

  assign man = an[W-1] ? -an : an;
  assign mad = ad[W-1] ? -ad : ad;
  assign mbn = bn[W-1] ? -bn : bn;
  assign mbd = bd[W-1] ? -bd : bd;

  always_comb begin
    unique case (step)
      2'd0:    begin opa = man; opb = (op == OP_MUL) ? mbn : mbd; end
      2'd1:    begin
        opa = (op == OP_MUL || op == OP_DIV) ? mad : mbn;
        opb = (op == OP_MUL) ? mbd : ((op == OP_DIV) ? mbn : mad);
      end
      default: begin opa = mad; opb = mbd; end
    endcase
  end
  assign prod = D'(opa) * D'(opb);

  // signs for add and subtract once denominators are made positive, and cross-product signs
  assign n1 = (an != '0) && (an[W-1] != ad[W-1]);
  assign n2 = (bn != '0) && ((bn[W-1] != bd[W-1]) != (op == OP_SUB));
  assign sa = an[W-1] ^ bd[W-1];
  assign sb = bn[W-1] ^ ad[W-1];

  assign tn = {rn, qn[D-1]};
  assign td = {rd, qd[D-1]};

  always_comb begin
    st_next = st;
    pop     = 1'b0;
    unique case (st)
      B_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          if (!cls.zden && cls.op != OP_SIGN && cls.op != OP_NONE) st_next = B_MUL;
        end
      end
      B_MUL: if (step == 2'd2) st_next = B_SET;
      B_SET: begin
        if (op == OP_EQ) st_next = B_IDLE;
        else if ((op == OP_ADD || op == OP_SUB) ? (n1 == n2 ? (p0 + p1) == '0 : p0 == p1)
                                                 : p0 == '0)
          st_next = B_IDLE;
        else st_next = B_GCD;
      end
      B_GCD: if (x == y) st_next = B_DIV;
      B_DIV: if (cnt == CW'(D - 1)) st_next = B_FIN;
      B_FIN: st_next = B_IDLE;
      default: st_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) st <= B_IDLE;
    else     st <= st_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        B_IDLE: begin
          step <= 2'd0;
          if (!empty) begin
            op <= cls.op;
            an <= qan; ad <= qad; bn <= qbn; bd <= qbd;
            res_num <= '0; res_den <= '0; verdict <= VERD_ZERO; error <= ERR_OK;
            if (cls.zden) begin
              error <= ERR_ZDEN;
              done  <= 1'b1;
            end else if (cls.op == OP_SIGN) begin
              if (qan != '0) verdict <= (qan[W-1] == qad[W-1]) ? VERD_POS : VERD_NEG;
              done <= 1'b1;
            end else if (cls.op == OP_NONE) begin
              done <= 1'b1;
            end
          end
        end
        B_MUL: begin
          unique case (step)
            2'd0:    p0 <= prod;
            2'd1:    p1 <= prod;
            default: p2 <= prod;
          endcase
          step <= step + 2'd1;
        end
        B_SET: begin
          k <= '0;
          priority if (op == OP_EQ) begin
            verdict <= ((p0 == p1) && (p0 == '0 || sa == sb)) ? VERD_POS : VERD_ZERO;
            done    <= 1'b1;
          end else if (op == OP_ADD || op == OP_SUB) begin
            nd <= 1'b0;
            x  <= p2; y <= p2; qd <= p2;
            if (n1 == n2) begin
              nn <= n1; x <= p0 + p1; qn <= p0 + p1;
              if ((p0 + p1) == '0) begin res_den <= W'(1); done <= 1'b1; end
            end else if (p0 >= p1) begin
              nn <= n1; x <= p0 - p1; qn <= p0 - p1;
              if (p0 == p1) begin res_den <= W'(1); done <= 1'b1; end
            end else begin
              nn <= n2; x <= p1 - p0; qn <= p1 - p0;
            end
          end else begin
            nn <= (op == OP_MUL) ? (an[W-1] ^ bn[W-1]) : sa;
            nd <= (op == OP_MUL) ? (ad[W-1] ^ bd[W-1]) : sb;
            x <= p0; qn <= p0; y <= p1; qd <= p1;
            if (p0 == '0) begin res_den <= W'(1); done <= 1'b1; end
          end
        end
        B_GCD: begin
          rn  <= '0;
          rd  <= '0;
          cnt <= '0;
          priority if (x == y) begin
            g <= x << k;
          end else if (!x[0] && !y[0]) begin
            x <= x >> 1; y <= y >> 1; k <= k + CW'(1);
          end else if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (x > y) begin
            x <= x - y;
          end else begin
            y <= y - x;
          end
        end
        B_DIV: begin
          cnt <= cnt + CW'(1);
          if (tn >= {1'b0, g}) begin
            rn <= D'(tn - {1'b0, g}); qn <= {qn[D-2:0], 1'b1};
          end else begin
            rn <= tn[D-1:0];          qn <= {qn[D-2:0], 1'b0};
          end
          if (td >= {1'b0, g}) begin
            rd <= D'(td - {1'b0, g}); qd <= {qd[D-2:0], 1'b1};
          end else begin
            rd <= td[D-1:0];          qd <= {qd[D-2:0], 1'b0};
          end
        end
        B_FIN: begin
          done <= 1'b1;
          if (qn > (nn ? HALF : HALF - D'(1)) || qd > (nd ? HALF : HALF - D'(1))) begin
            error <= ERR_RANGE;
          end else begin
            res_num <= nn ? -qn[W-1:0] : qn[W-1:0];
            res_den <= nd ? -qd[W-1:0] : qd[W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/rau_check.sv =====
module rau_check #(
  parameter int FRAC_BITS = rau_pkg::FRAC_BITS_DEF
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic [2:0]           kind,
  input logic [FRAC_BITS-1:0] a_num,
  input logic [FRAC_BITS-1:0] a_den,
  input logic [FRAC_BITS-1:0] b_num,
  input logic [FRAC_BITS-1:0] b_den,
  input logic                 done,
  input logic [FRAC_BITS-1:0] res_num,
  input logic [FRAC_BITS-1:0] res_den,
  input logic [1:0]           verdict,
  input logic [1:0]           error
);
  import rau_pkg::*;

  a_err_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (error == ERR_OK || error == ERR_RANGE || error == ERR_ZDEN))
    else $error("bad error code");

  a_err_clear: assert property (@(posedge clk) disable iff (rst)
    done && error != ERR_OK |-> res_num == '0 && res_den == '0 && verdict == VERD_ZERO)
    else $error("error word carries data");

  a_zero_form: assert property (@(posedge clk) disable iff (rst)
    done && res_num == '0 && res_den != '0 |-> res_den == FRAC_BITS'(1))
    else $error("zero result not 0/1");

  a_verdict_excl: assert property (@(posedge clk) disable iff (rst)
    done && res_den != '0 |-> verdict == VERD_ZERO)
    else $error("verdict with fraction result");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done && !busy)
    else $error("activity right after reset");

endmodule

bind rational_arithmetic_unit rau_check #(.FRAC_BITS(FRAC_BITS)) u_rau_check (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import rau_pkg::*;

  localparam int FB = 16;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic [FB-1:0] num;
    logic [FB-1:0] den;
    logic [1:0]    verdict;
    logic [1:0]    error;
  } frac_word_t;

  int fail_count = 0;

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    fail_count++;
  endtask

  class rau_scoreboard;
    frac_word_t pending[$];

    // gcd of magnitudes
    function automatic longint unsigned gcd_mag(longint unsigned x, longint unsigned y);
      longint unsigned t;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      return x;
    endfunction

    function automatic void reduce_into(ref frac_word_t r, input bit nn,
                                        input longint unsigned mn, input bit nd,
                                        input longint unsigned md);
      longint unsigned g;
      if (mn == 0) begin
        r.num = '0;
        r.den = FB'(1);
        return;
      end
      g = gcd_mag(mn, md);
      mn /= g;
      md /= g;
      if ((nn ? mn > 32768 : mn > 32767) || (nd ? md > 32768 : md > 32767)) begin
        r.error = ERR_RANGE;
        return;
      end
      r.num = nn ? FB'(-mn) : FB'(mn);
      r.den = nd ? FB'(-md) : FB'(md);
    endfunction

    function automatic frac_word_t compute(logic [2:0] k, logic signed [FB-1:0] an,
                                           logic signed [FB-1:0] ad,
                                           logic signed [FB-1:0] bn,
                                           logic signed [FB-1:0] bd);
      frac_word_t r;
      longint signed pan, pbn, ma, mb, mc, md_;
      longint unsigned m1, m2, mn;
      bit n1, n2, nn;
      r.num = '0; r.den = '0; r.verdict = VERD_ZERO; r.error = ERR_OK;
      ma = an; mb = ad; mc = bn; md_ = bd;
      if (k == KIND_SIGN) begin
        if (mb == 0) r.error = ERR_ZDEN;
        else if (ma != 0) r.verdict = ((ma > 0) == (mb > 0)) ? VERD_POS : VERD_NEG;
        return r;
      end
      if (k > KIND_EQ) return r;
      if (mb == 0 || md_ == 0 || (k == KIND_DIV && mc == 0)) begin
        r.error = ERR_ZDEN;
        return r;
      end
      case (k)
        KIND_EQ: r.verdict = (ma * md_ == mc * mb) ? VERD_POS : VERD_ZERO;
        KIND_ADD, KIND_SUB: begin
          pan = mb < 0 ? -ma : ma;
          pbn = md_ < 0 ? -mc : mc;
          if (k == KIND_SUB) pbn = -pbn;
          n1 = pan < 0;
          n2 = pbn < 0;
          m1 = (pan < 0 ? -pan : pan) * (md_ < 0 ? -md_ : md_);
          m2 = (pbn < 0 ? -pbn : pbn) * (mb < 0 ? -mb : mb);
          if (n1 == n2) begin nn = n1; mn = m1 + m2; end
          else if (m1 >= m2) begin nn = n1; mn = m1 - m2; end
          else begin nn = n2; mn = m2 - m1; end
          reduce_into(r, nn, mn, 1'b0,
                      (mb < 0 ? -mb : mb) * (md_ < 0 ? -md_ : md_));
        end
        KIND_MUL: reduce_into(r, (ma < 0) != (mc < 0),
                              (ma < 0 ? -ma : ma) * (mc < 0 ? -mc : mc),
                              (mb < 0) != (md_ < 0),
                              (mb < 0 ? -mb : mb) * (md_ < 0 ? -md_ : md_));
        default: reduce_into(r, (ma < 0) != (md_ < 0),
                             (ma < 0 ? -ma : ma) * (md_ < 0 ? -md_ : md_),
                             (mb < 0) != (mc < 0),
                             (mb < 0 ? -mb : mb) * (mc < 0 ? -mc : mc));
      endcase
      return r;
    endfunction

    function void note_input(logic [2:0] k, logic [FB-1:0] an, logic [FB-1:0] ad,
                             logic [FB-1:0] bn, logic [FB-1:0] bd);
      pending.push_back(compute(k, an, ad, bn, bd));
    endfunction

    task check_result(frac_word_t got);
      frac_word_t exp_w;
      if (pending.size() == 0) begin
        report("result word with nothing expected");
        return;
      end
      exp_w = pending.pop_front();
      if (got.num !== exp_w.num)
        report($sformatf("res_num %h, expected %h", got.num, exp_w.num));
      if (got.den !== exp_w.den)
        report($sformatf("res_den %h, expected %h", got.den, exp_w.den));
      if (got.verdict !== exp_w.verdict)
        report($sformatf("verdict %b, expected %b", got.verdict, exp_w.verdict));
      if (got.error !== exp_w.error)
        report($sformatf("error %0d, expected %0d", got.error, exp_w.error));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic [2:0] kind = '0;
  logic [FB-1:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
  logic done;
  logic [FB-1:0] res_num, res_den;
  logic [1:0] verdict, error;

  rau_scoreboard sb = new();
  int idle_pct = 0;
  int quiet_cycles = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  rational_arithmetic_unit #(.FRAC_BITS(FB)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
    .done(done), .res_num(res_num), .res_den(res_den),
    .verdict(verdict), .error(error)
  );

  always @(posedge clk) begin
    frac_word_t got;
    if (!rst && start && !busy) begin
      sb.note_input(kind, a_num, a_den, b_num, b_den);
      quiet_cycles <= 0;
    end else if (!rst && done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (!rst && done) begin
      got.num = res_num; got.den = res_den;
      got.verdict = verdict; got.error = error;
      sb.check_result(got);
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // one word; start stays high across back-to-back words
  task automatic send_word(logic [2:0] k, logic [FB-1:0] an, logic [FB-1:0] ad,
                           logic [FB-1:0] bn, logic [FB-1:0] bd);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    kind <= k; a_num <= an; a_den <= ad; b_num <= bn; b_den <= bd;
    start <= 1'b1;
    // busy only moves at rising edges, so it is stable here
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  function automatic logic [FB-1:0] rand_field();
    case ($urandom_range(5))
      0: return FB'($urandom_range(0, 9));
      1: return -FB'($urandom_range(1, 9));
      2: return FB'($urandom_range(0, 255)) - 16'd128;
      3: return {1'b1, 15'($urandom)} ^ {1'($urandom_range(1)), 15'd0};
      4: return FB'($urandom_range(0, 3)) ^ 16'h8000 ^
                (($urandom_range(1) != 0) ? 16'h7fff : 16'h0000);
      default: return FB'($urandom);
    endcase
  endfunction

  function automatic logic [FB-1:0] rand_den();
    // zero rarely, so most words reach the arithmetic path
    return ($urandom_range(29) == 0) ? '0 : rand_field();
  endfunction

  initial begin
    logic [FB-1:0] an, ad, bn, bd;
    logic [2:0] k;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_word(KIND_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
    send_word(KIND_SUB, 16'd1, 16'd2, 16'd1, 16'd2);
    send_word(KIND_MUL, 16'h8000, 16'd1, 16'h8000, 16'd1);
    send_word(KIND_MUL, 16'h8000, 16'hffff, 16'd1, 16'd1);
    send_word(KIND_DIV, 16'd3, 16'hfffc, 16'hfffe, 16'd5);
    send_word(KIND_DIV, 16'd3, 16'd4, 16'd0, 16'd5);
    send_word(KIND_ADD, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
    send_word(KIND_ADD, 16'h7fff, 16'd1, 16'h7fff, 16'd1);
    send_word(KIND_SUB, 16'h8000, 16'hffff, 16'd5, 16'hfffe);
    send_word(KIND_SIGN, 16'hfffb, 16'hfffd, 16'd0, 16'd0);
    send_word(KIND_SIGN, 16'd5, 16'hfffd, 16'd1, 16'd1);
    send_word(KIND_SIGN, 16'd0, 16'hfffd, 16'd1, 16'd1);
    send_word(KIND_SIGN, 16'd7, 16'd0, 16'd1, 16'd1);
    send_word(KIND_EQ, 16'd1, 16'd2, 16'hfffe, 16'hfffc);
    send_word(KIND_EQ, 16'd1, 16'd2, 16'd1, 16'd3);
    send_word(KIND_EQ, 16'd1, 16'd2, 16'd1, 16'd0);
    send_word(KIND_ADD, 16'd1, 16'd0, 16'd1, 16'd3);
    send_word(3'd6, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_word(3'd7, 16'h1234, 16'd0, 16'h8000, 16'd0);
    send_word(KIND_MUL, 16'd0, 16'hffff, 16'd9, 16'd4);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: idle_pct = 0;
        1: idle_pct = 63;
        2: idle_pct = 0;
        default: idle_pct = 28;
      endcase
      for (int i = 0; i < 358; i++) begin
        k = ($urandom_range(19) == 0) ? 3'($urandom_range(6, 7))
                                      : 3'($urandom_range(0, 5));
        an = rand_field(); ad = rand_den(); bn = rand_field(); bd = rand_den();
        if (k == KIND_EQ && $urandom_range(2) == 0) begin
          bn = an; bd = ad;
        end
        send_word(k, an, ad, bn, bd);
      end
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (fail_count == 0 && sb.pending.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
